>>> hdl/dafs_pkg.sv
// ---------------------------------------------------------------------------
// dafs_pkg: shared definitions of the averaging frame sender
// Sizes, frame codes, register indexes and control structs.
// ---------------------------------------------------------------------------
package dafs_pkg;

  localparam int CHANNELS    = 10;
  localparam int SAMPLE_BITS = 32;
  localparam int SLOT_BITS   = 32;
  localparam int SUM_BITS    = 36;
  localparam int RATIO_W     = 4;
  localparam int FRAME_BYTES = 4 * CHANNELS + 4;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int DIV_STEPS   = 7;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 2;

  localparam logic [7:0] FRAME_HEAD0 = 8'h5A;
  localparam logic [7:0] FRAME_HEAD1 = 8'hA5;
  localparam logic [7:0] FRAME_TAIL0 = 8'h0D;
  localparam logic [7:0] FRAME_TAIL1 = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIM  = 2'd0,
    CFG_PIN_EN = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DECIM_1  = 2'd0,
    DECIM_2  = 2'd1,
    DECIM_10 = 2'd2
  } decim_e;

  // steps of the divide by ten, in order
  typedef enum logic [DIV_CNT_W-1:0] {
    DIV_SEED  = 3'd0,
    DIV_ADD4  = 3'd1,
    DIV_ADD8  = 3'd2,
    DIV_ADD16 = 3'd3,
    DIV_ADD32 = 3'd4,
    DIV_REM   = 3'd5,
    DIV_FIX   = 3'd6
  } div_step_e;

  typedef logic [CHANNELS-1:0][SLOT_BITS-1:0] means_t;

  // per-lane accumulate and divide controls
  typedef struct packed {
    logic               acc_en;
    logic               clear;
    logic               start;
    logic               step;
    div_step_e          stage;
    logic [RATIO_W-1:0] ratio;
  } lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic pin_en;
  } snd_load_t;

  function automatic logic [RATIO_W-1:0] ratio_of(input logic [1:0] sel);
    logic [RATIO_W-1:0] r;
    case (sel)
      DECIM_2:  r = RATIO_W'(2);
      DECIM_10: r = RATIO_W'(10);
      default:  r = RATIO_W'(1);
    endcase
    return r;
  endfunction

endpackage

>>> hdl/dafs_lane.sv
// ---------------------------------------------------------------------------
// dafs_lane: one channel lane
// Accumulates samples into a 36-bit sum and divides a captured sum by the
// ratio with a few shift-and-add steps, then saturates the mean.
// ---------------------------------------------------------------------------
module dafs_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dafs_pkg::lane_ctrl_t        ctrl_i,
  input  logic [dafs_pkg::SLOT_BITS-1:0] sample_i,
  output logic [dafs_pkg::SLOT_BITS-1:0] mean_o
);
  import dafs_pkg::*;

  localparam logic [SUM_BITS-1:0] SAT_POS = SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [SUM_BITS-1:0] SAT_NEG = SUM_BITS'(64'd1 << (SAMPLE_BITS - 1));

  logic [SUM_BITS-1:0] sum_q, sum_d, sum_next;
  logic [SUM_BITS-1:0] mag_q, mag_d;
  logic [SUM_BITS-1:0] quo_q, quo_d;
  logic [4:0]          rem_q, rem_d;
  logic                neg_q, neg_d;
  logic [SUM_BITS-1:0] rem_full;
  logic [SUM_BITS-1:0] sel_mag;
  logic [SUM_BITS-1:0] lim, neg_val;
  logic [SAMPLE_BITS-1:0] res;

  assign sum_next = sum_q + SUM_BITS'(signed'(sample_i[SAMPLE_BITS-1:0]));

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.acc_en) begin
      sum_d = ctrl_i.clear ? '0 : sum_next;
    end
  end

  // divide by ten: series for 0.8 of the magnitude, shift by three, then
  // the estimate is at most one low and a remainder check fixes it
  always_comb begin
    rem_full = mag_q - ((quo_q << 3) + (quo_q << 1));
    mag_d = mag_q;
    quo_d = quo_q;
    rem_d = rem_q;
    neg_d = neg_q;
    if (ctrl_i.start) begin
      neg_d = sum_next[SUM_BITS-1];
      mag_d = sum_next[SUM_BITS-1] ? (~sum_next + SUM_BITS'(1)) : sum_next;
    end else if (ctrl_i.step) begin
      case (ctrl_i.stage)
        DIV_SEED:  quo_d = (mag_q >> 1) + (mag_q >> 2);
        DIV_ADD4:  quo_d = quo_q + (quo_q >> 4);
        DIV_ADD8:  quo_d = quo_q + (quo_q >> 8);
        DIV_ADD16: quo_d = quo_q + (quo_q >> 16);
        DIV_ADD32: quo_d = (quo_q + (quo_q >> 32)) >> 3;
        DIV_REM:   rem_d = rem_full[4:0];
        DIV_FIX:   quo_d = quo_q + SUM_BITS'(rem_q > 5'd9);
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  always_comb begin
    case (ctrl_i.ratio)
      RATIO_W'(1): sel_mag = mag_q;
      RATIO_W'(2): sel_mag = mag_q >> 1;
      default:     sel_mag = quo_q;
    endcase
  end

  // saturate the magnitude, then restore the sign
  always_comb begin
    if (neg_q) begin
      lim     = (sel_mag > SAT_NEG) ? SAT_NEG : sel_mag;
      neg_val = ~lim + SUM_BITS'(1);
      res     = neg_val[SAMPLE_BITS-1:0];
    end else begin
      lim     = (sel_mag > SAT_POS) ? SAT_POS : sel_mag;
      neg_val = lim;
      res     = lim[SAMPLE_BITS-1:0];
    end
  end

  assign mean_o = SLOT_BITS'(signed'(res));

endmodule

>>> hdl/dafs_sender.sv
// ---------------------------------------------------------------------------
// dafs_sender: frame serializer
// Holds one set of means and streams the 44-byte frame through an output
// register, one byte per cycle while m_axis_tready is high.
// ---------------------------------------------------------------------------
module dafs_sender (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dafs_pkg::snd_load_t load_i,
  input  dafs_pkg::means_t    means_i,
  output logic                free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // frame_byte
  output logic                m_axis_tlast,
  output logic [0:0]          m_axis_tuser    // data_ready_pin
);
  import dafs_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  means_t           means_q;
  logic             active_q, active_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             pin_q, pin_d;
  logic             vld_q, vld_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;
  logic             user_q, user_d;
  logic [IDX_W-1:0] off;
  logic [CH_W-1:0]  ch;
  logic [SLOT_BITS-1:0] word;
  logic [7:0]       byte_val;
  logic             advance;

  always_comb begin
    off  = idx_q - IDX_W'(2);
    ch   = CH_W'(off >> 2);
    word = means_q[ch];
    if (idx_q == IDX_W'(0)) begin
      byte_val = FRAME_HEAD0;
    end else if (idx_q == IDX_W'(1)) begin
      byte_val = FRAME_HEAD1;
    end else if (idx_q == IDX_W'(FRAME_BYTES - 2)) begin
      byte_val = FRAME_TAIL0;
    end else if (idx_q == LAST_IDX) begin
      byte_val = FRAME_TAIL1;
    end else begin
      byte_val = word[8*off[1:0] +: 8];
    end
  end

  assign advance = active_q && (!vld_q || m_axis_tready);

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    pin_d    = pin_q;
    vld_d    = vld_q;
    data_d   = data_q;
    last_d   = last_q;
    user_d   = user_q;
    if (load_i.load) begin
      active_d = 1'b1;
      idx_d    = '0;
      pin_d    = load_i.pin_en;
    end
    if (advance) begin
      vld_d  = 1'b1;
      data_d = byte_val;
      last_d = (idx_q == LAST_IDX);
      user_d = pin_q;
      idx_d  = idx_q + IDX_W'(1);
      if (idx_q == LAST_IDX) begin
        active_d = 1'b0;
      end
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      pin_q    <= 1'b0;
      vld_q    <= 1'b0;
      data_q   <= '0;
      last_q   <= 1'b0;
      user_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      pin_q    <= pin_d;
      vld_q    <= vld_d;
      data_q   <= data_d;
      last_q   <= last_d;
      user_q   <= user_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      means_q <= means_i;
    end
  end

  assign free_o        = !active_q;
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = user_q;

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.load |-> !active_q)
    else $error("frame loaded while previous frame still streaming");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && idx_q == LAST_IDX) |=> (!active_q && last_q))
    else $error("final byte did not close the frame");

  a_tail_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && last_q) |-> (data_q == FRAME_TAIL1))
    else $error("last flag on a byte other than the tail");

endmodule

>>> hdl/decimating_average_frame_sender.sv
// ---------------------------------------------------------------------------
// decimating_average_frame_sender: boxcar average and frame emitter
// Ten channel lanes sum samples per tick; at the ratio, if transmitter_ready,
// each lane divides its sum and the sender streams the 44-byte frame of means.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: 10 samples x 32 bits; tuser: transmitter_ready
//  m_axis    out        tdata: frame_byte; tlast: last_of_frame;
//                       tuser: data_ready_pin
//  cfg       in         index 0: decimation_select, 1: ready_pin_enable
//
//  a tick that does not send a frame is taken every cycle
//  a sending tick starts a shift-and-add divide in every lane; the first byte
//  is valid once the divide ends and the sender loads the means and registers it
//  the next sending tick waits until the means move to the sender, which takes
//  them only when free of its last frame, so the byte-wide output sets the rate
//  the frame streams at one byte per cycle while m_axis_tready is high
//  reset clears sums, tick count, control registers and the output; no clearing pass
// ---------------------------------------------------------------------------
module decimating_average_frame_sender (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // roll, pitch, yaw, gyro x/y/z, accel x/y/z, temperature (32 bits each)
  input  logic [dafs_pkg::CHANNELS*dafs_pkg::SLOT_BITS-1:0] s_axis_tdata,
  input  logic [0:0]                             s_axis_tuser,  // transmitter_ready
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [7:0]                             m_axis_tdata,  // frame_byte
  output logic                                   m_axis_tlast,
  output logic [0:0]                             m_axis_tuser,  // data_ready_pin
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dafs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [dafs_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import dafs_pkg::*;

  logic [1:0]           sel_q, sel_d;
  logic                 pen_q, pen_d;
  logic [3:0]           tick_q, tick_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [RATIO_W-1:0]   ratio_q, ratio_d;
  logic [RATIO_W-1:0]   ratio_now;
  logic                 fire, send, acc, start, xfer, snd_free;
  lane_ctrl_t           lane_ctrl;
  snd_load_t            snd_load;
  means_t               means;

  assign ratio_now = ratio_of(sel_q);
  assign fire      = ({1'b0, tick_q} + 5'd1) >= {1'b0, ratio_now};
  assign send      = fire && s_axis_tuser[0];
  // a sending tick needs the lane dividers free
  assign s_axis_tready = !(send && (run_q || done_q));
  assign acc       = s_axis_tvalid && s_axis_tready;
  assign start     = acc && send;
  assign xfer      = done_q && snd_free;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    lane_ctrl.acc_en = acc;
    lane_ctrl.clear  = fire;
    lane_ctrl.start  = start;
    lane_ctrl.step   = run_q;
    lane_ctrl.stage  = div_step_e'(cnt_q);
    lane_ctrl.ratio  = ratio_q;
    snd_load.load    = xfer;
    snd_load.pin_en  = pen_q;
  end

  always_comb begin
    sel_d   = sel_q;
    pen_d   = pen_q;
    tick_d  = tick_q;
    run_d   = run_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    ratio_d = ratio_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DECIM:  sel_d = cfg_data_i[1:0];
        CFG_PIN_EN: pen_d = cfg_data_i[0];
        default:    ;
      endcase
    end
    if (acc) begin
      tick_d = fire ? 4'd0 : tick_q + 4'd1;
    end
    if (start) begin
      run_d   = 1'b1;
      cnt_d   = '0;
      ratio_d = ratio_now;
    end else if (run_q) begin
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
    if (xfer) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= DECIM_1;
      pen_q   <= 1'b0;
      tick_q  <= '0;
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      ratio_q <= RATIO_W'(1);
    end else begin
      sel_q   <= sel_d;
      pen_q   <= pen_d;
      tick_q  <= tick_d;
      run_q   <= run_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      ratio_q <= ratio_d;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    dafs_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (s_axis_tdata[c*SLOT_BITS +: SLOT_BITS]),
      .mean_o   (means[c])
    );
  end

  dafs_sender u_sender (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (snd_load),
    .means_i       (means),
    .free_o        (snd_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_div_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q && done_q))
    else $error("divider running and holding a result at once");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !(run_q || done_q))
    else $error("divide started over a pending one");

  a_div_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) |=> (done_q && !run_q))
    else $error("divide did not finish after its last step");

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q <= 4'd9)
    else $error("tick count passed the largest ratio");

endmodule
